>>> hw/rtl/mesh_face_vertex_normals_core_assert.svh
// Assertion macros used by the checker file mfvn_checker.sv.
`ifndef MESH_FACE_VERTEX_NORMALS_CORE_ASSERT_SVH
`define MESH_FACE_VERTEX_NORMALS_CORE_ASSERT_SVH

// same-cycle implication
`define MFVN_ASSERT_IMP(name, clk, rstn, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
        else $error("mfvn assertion failed");

// next-cycle implication
`define MFVN_ASSERT_NXT(name, clk, rstn, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
        else $error("mfvn assertion failed");

`endif

>>> hw/rtl/mfvn_pkg.sv
`default_nettype none

package mfvn_pkg;

    localparam int IDX_W          = 10;
    localparam int IN_COORD_W     = 16;
    localparam int SUM_W          = 32;
    localparam int Q_W            = 15;
    localparam int NORM_W         = 16;
    localparam int DIV_STEPS      = 15;
    localparam int CROSS_PRODUCTS = 6;
    localparam int SQ_PRODUCTS    = 9;
    localparam int S_DATA_W       = 80;
    localparam int M_DATA_W       = 64;

    localparam logic KIND_FACE   = 1'b0;
    localparam logic KIND_VERTEX = 1'b1;

    localparam logic [SUM_W-1:0] SUM_MAX = 32'h7FFF_FFFF;
    localparam logic [SUM_W-1:0] SUM_MIN = 32'h8000_0000;

    typedef enum logic [1:0] {
        CMD_LOAD = 2'd0,
        CMD_TRI  = 2'd1,
        CMD_READ = 2'd2,
        CMD_NONE = 2'd3
    } cmd_t;

    // partial products of a split square: hi*hi, hi*lo, lo*lo
    typedef enum logic [1:0] {
        PART_HH = 2'd0,
        PART_HL = 2'd1,
        PART_LL = 2'd2
    } sq_part_t;

    typedef struct packed {
        logic [1:0] comp;
        sq_part_t   part;
    } sq_sel_t;

    function automatic sq_sel_t sq_sel(input logic [3:0] tag);
        sq_sel_t s;
        case (tag)
            4'd0:    s = '{comp: 2'd0, part: PART_HH};
            4'd1:    s = '{comp: 2'd0, part: PART_HL};
            4'd2:    s = '{comp: 2'd0, part: PART_LL};
            4'd3:    s = '{comp: 2'd1, part: PART_HH};
            4'd4:    s = '{comp: 2'd1, part: PART_HL};
            4'd5:    s = '{comp: 2'd1, part: PART_LL};
            4'd6:    s = '{comp: 2'd2, part: PART_HH};
            4'd7:    s = '{comp: 2'd2, part: PART_HL};
            default: s = '{comp: 2'd2, part: PART_LL};
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/mfvn_ram.sv
`default_nettype none

module mfvn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> hw/rtl/mfvn_alu.sv
`default_nettype none

// Shared arithmetic: a registered signed multiplier (cross product, square) and
// an unsigned trial subtractor used by both the square root and the divider.
module mfvn_alu #(
    parameter int MUL_W = 18,
    parameter int SUB_W = 38
) (
    input  wire logic                      aclk,
    input  wire logic                      mul_en,
    input  wire logic signed [MUL_W-1:0]   mul_a,
    input  wire logic signed [MUL_W-1:0]   mul_b,
    output logic signed      [2*MUL_W-1:0] prod,
    input  wire logic        [SUB_W-1:0]   sub_a,
    input  wire logic        [SUB_W-1:0]   sub_b,
    output logic             [SUB_W-1:0]   sub_diff,
    output logic                           sub_ge
);

    logic signed [2*MUL_W-1:0] prod_reg;
    logic        [SUB_W:0]     diff_ext;

    always_ff @(posedge aclk) begin
        if (mul_en) begin
            prod_reg <= mul_a * mul_b;
        end
    end

    assign prod     = prod_reg;
    assign diff_ext = {1'b0, sub_a} - {1'b0, sub_b};
    assign sub_diff = diff_ext[SUB_W-1:0];
    assign sub_ge   = ~diff_ext[SUB_W];

endmodule

`default_nettype wire

>>> hw/rtl/mesh_face_vertex_normals_core.sv
// Fixed-point mesh normal engine.
// Input words (s_*): s_tuser carries the command (load vertex, triangle, read vertex
// normal); s_tdata carries three vertex indices and a position. A load gives no
// result. A triangle gives its Q1.14 unit face normal and adds it into the saturating
// normal sums of its in-range corners; a read gives the normalized sum.
// Result words (m_*) sit in an output register; the next command is accepted while a
// result waits, and the engine only holds in its emit step if the previous result has
// not been taken when the new one is ready.
// Steps per command:
//   triangle: accept, fetch, cross, square, root, divide, emit, sum updates;
//   read:     accept, fetch, square, root, divide, emit.
// The single multiplier and the single trial subtractor are shared among these steps:
// the root takes one bit per cycle and each of the three quotients one bit per cycle.
// Degenerate vectors skip the divide. s_tready stays low while a command is in flight.
// Reset: after aresetn, a clearing pass writes zero into all VERTEX_COUNT normal sums,
// one entry per cycle, with s_tready low; positions are undefined until loaded.
`default_nettype none

module mesh_face_vertex_normals_core #(
    parameter int VERTEX_COUNT = 1024,
    parameter int COORD_BITS   = 16
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // first_index, second_index, third_index, coord_x, coord_y, coord_z, zero pad
    input  wire logic [mfvn_pkg::S_DATA_W-1:0]     s_tdata,
    // cmd
    input  wire logic [1:0]                        s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // result_index, normal_x, normal_y, normal_z, zero pad
    output logic      [mfvn_pkg::M_DATA_W-1:0]     m_tdata,
    // result_kind, degenerate
    output logic      [1:0]                        m_tuser
);

    localparam int AW     = $clog2(VERTEX_COUNT);
    localparam int CB     = COORD_BITS;
    localparam int EW     = CB + 1;
    localparam int MW     = (2 * EW > 32) ? 2 * EW : 32;
    localparam int CW     = MW + 1;
    localparam int HB     = (MW + 1) / 2;
    localparam int MUL_W  = ((EW > HB) ? EW : HB) + 1;
    localparam int PW     = 2 * MUL_W;
    localparam int SW     = 2 * MW + 2;
    localparam int NSQ    = MW + 1;
    localparam int SUB_W  = NSQ + 3;
    localparam int STEP_W = $clog2(NSQ + 1);
    localparam int IW     = mfvn_pkg::IDX_W;
    localparam int NW     = mfvn_pkg::NORM_W;
    localparam int QW     = mfvn_pkg::Q_W;
    localparam int SMW    = mfvn_pkg::SUM_W;

    typedef enum logic [8:0] {
        ST_CLEAR = 9'b000000001,
        ST_IDLE  = 9'b000000010,
        ST_FETCH = 9'b000000100,
        ST_CROSS = 9'b000001000,
        ST_SQ    = 9'b000010000,
        ST_SQRT  = 9'b000100000,
        ST_DIV   = 9'b001000000,
        ST_EMIT  = 9'b010000000,
        ST_WB    = 9'b100000000
    } state_t;

    function automatic logic in_range(input logic [IW-1:0] i);
        return int'(i) < VERTEX_COUNT;
    endfunction

    function automatic logic [MW-1:0] mag_of(input logic signed [CW-1:0] v);
        logic signed [CW-1:0] t;
        t = v[CW-1] ? -v : v;
        return t[MW-1:0];
    endfunction

    function automatic logic [SMW-1:0] sat_add(input logic [SMW-1:0] a,
                                               input logic signed [NW-1:0] n);
        logic signed [SMW:0] t;
        t = $signed({a[SMW-1], a}) + (SMW+1)'(n);
        if (t[SMW] != t[SMW-1]) begin
            return t[SMW] ? mfvn_pkg::SUM_MIN : mfvn_pkg::SUM_MAX;
        end
        return t[SMW-1:0];
    endfunction

    // control
    state_t              state_reg, state_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [1:0]          comp_reg, comp_next;
    logic [3:0]          tag_reg, tag_next;
    logic                pv_reg, pv_next;
    logic                wb_ph_reg, wb_ph_next;
    logic [AW-1:0]       clr_cnt_reg, clr_cnt_next;
    logic                m_valid_reg, m_valid_next;

    // payload
    logic                       is_read_reg, is_read_next;
    logic [IW-1:0]              idx_reg [3];
    logic [IW-1:0]              idx_next [3];
    logic [2:0]                 ok_reg, ok_next;
    logic signed [CB-1:0]       p0_reg [3];
    logic signed [CB-1:0]       p0_next [3];
    logic signed [EW-1:0]       e1_reg [3];
    logic signed [EW-1:0]       e1_next [3];
    logic signed [EW-1:0]       e2_reg [3];
    logic signed [EW-1:0]       e2_next [3];
    logic signed [CW-1:0]       c_reg [3];
    logic signed [CW-1:0]       c_next [3];
    logic [SW-1:0]              s_reg, s_next;
    logic [SUB_W-1:0]           rem_reg, rem_next;
    logic [NSQ-1:0]             root_reg, root_next;
    logic [QW-1:0]              q_reg, q_next;
    logic signed [NW-1:0]       n_reg [3];
    logic signed [NW-1:0]       n_next [3];
    logic                       deg_reg, deg_next;
    logic                       m_kind_reg, m_kind_next;
    logic [IW-1:0]              m_idx_reg, m_idx_next;
    logic signed [NW-1:0]       m_n_reg [3];
    logic signed [NW-1:0]       m_n_next [3];
    logic                       m_deg_reg, m_deg_next;

    // memories and shared unit
    logic                  pos_we, pos_re;
    logic [AW-1:0]         pos_waddr, pos_raddr;
    logic [3*CB-1:0]       pos_wdata, pos_rdata;
    logic                  sum_we, sum_re;
    logic [AW-1:0]         sum_waddr, sum_raddr;
    logic [3*SMW-1:0]      sum_wdata, sum_rdata;
    logic                  mul_en;
    logic signed [MUL_W-1:0] mul_a, mul_b;
    logic signed [PW-1:0]  prod;
    logic [SUB_W-1:0]      sub_a, sub_b, sub_diff;
    logic                  sub_ge;

    // input word fields
    logic [IW-1:0]              in_idx [3];
    logic [mfvn_pkg::IN_COORD_W-1:0] in_coord [3];
    mfvn_pkg::cmd_t             in_cmd;
    logic                       in_acc;

    assign in_idx[0]   = s_tdata[IW-1:0];
    assign in_idx[1]   = s_tdata[2*IW-1:IW];
    assign in_idx[2]   = s_tdata[3*IW-1:2*IW];
    assign in_coord[0] = s_tdata[3*IW +: 16];
    assign in_coord[1] = s_tdata[3*IW+16 +: 16];
    assign in_coord[2] = s_tdata[3*IW+32 +: 16];
    assign in_cmd      = mfvn_pkg::cmd_t'(s_tuser);
    assign s_tready    = (state_reg == ST_IDLE);
    assign in_acc      = s_tvalid && s_tready;

    mfvn_ram #(.WIDTH(3 * CB), .DEPTH(VERTEX_COUNT)) u_pos_ram (
        .aclk  (aclk),
        .we    (pos_we),
        .waddr (pos_waddr),
        .wdata (pos_wdata),
        .re    (pos_re),
        .raddr (pos_raddr),
        .rdata (pos_rdata)
    );

    mfvn_ram #(.WIDTH(3 * SMW), .DEPTH(VERTEX_COUNT)) u_sum_ram (
        .aclk  (aclk),
        .we    (sum_we),
        .waddr (sum_waddr),
        .wdata (sum_wdata),
        .re    (sum_re),
        .raddr (sum_raddr),
        .rdata (sum_rdata)
    );

    mfvn_alu #(.MUL_W(MUL_W), .SUB_W(SUB_W)) u_alu (
        .aclk     (aclk),
        .mul_en   (mul_en),
        .mul_a    (mul_a),
        .mul_b    (mul_b),
        .prod     (prod),
        .sub_a    (sub_a),
        .sub_b    (sub_b),
        .sub_diff (sub_diff),
        .sub_ge   (sub_ge)
    );

    always_comb begin
        logic signed [CB-1:0]  pc;
        mfvn_pkg::sq_sel_t     sel;
        logic [MW-1:0]         mv;
        logic [MW-HB-1:0]      hi;
        logic [HB-1:0]         lo;
        logic [SW-1:0]         addend;
        logic signed [NW-1:0]  qs;
        logic [QW-1:0]         qf;

        pc     = '0;
        sel    = mfvn_pkg::sq_sel(4'd0);
        mv     = '0;
        hi     = '0;
        lo     = '0;
        addend = '0;
        qs     = '0;
        qf     = '0;

        state_next   = state_reg;
        step_next    = step_reg;
        comp_next    = comp_reg;
        tag_next     = tag_reg;
        pv_next      = 1'b0;
        wb_ph_next   = wb_ph_reg;
        clr_cnt_next = clr_cnt_reg;
        m_valid_next = m_valid_reg && !m_tready;
        is_read_next = is_read_reg;
        idx_next     = idx_reg;
        ok_next      = ok_reg;
        p0_next      = p0_reg;
        e1_next      = e1_reg;
        e2_next      = e2_reg;
        c_next       = c_reg;
        s_next       = s_reg;
        rem_next     = rem_reg;
        root_next    = root_reg;
        q_next       = q_reg;
        n_next       = n_reg;
        deg_next     = deg_reg;
        m_kind_next  = m_kind_reg;
        m_idx_next   = m_idx_reg;
        m_n_next     = m_n_reg;
        m_deg_next   = m_deg_reg;

        pos_we    = 1'b0;
        pos_re    = 1'b0;
        pos_waddr = AW'(in_idx[0]);
        pos_raddr = AW'(idx_reg[0]);
        pos_wdata = {CB'(in_coord[2]), CB'(in_coord[1]), CB'(in_coord[0])};
        sum_we    = 1'b0;
        sum_re    = 1'b0;
        sum_waddr = AW'(in_idx[0]);
        sum_raddr = AW'(idx_reg[0]);
        sum_wdata = '0;
        mul_en    = 1'b0;
        mul_a     = '0;
        mul_b     = '0;
        sub_a     = '0;
        sub_b     = '0;

        unique case (state_reg)
            ST_CLEAR: begin
                sum_we       = 1'b1;
                sum_waddr    = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == AW'(VERTEX_COUNT - 1)) begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE: begin
                if (in_acc) begin
                    idx_next     = in_idx;
                    ok_next      = {in_range(in_idx[2]), in_range(in_idx[1]),
                                    in_range(in_idx[0])};
                    is_read_next = (in_cmd == mfvn_pkg::CMD_READ);
                    step_next    = '0;
                    unique case (in_cmd) inside
                        mfvn_pkg::CMD_LOAD: begin
                            // loading a vertex also restarts its normal sum
                            pos_we = in_range(in_idx[0]);
                            sum_we = in_range(in_idx[0]);
                        end
                        mfvn_pkg::CMD_TRI, mfvn_pkg::CMD_READ: begin
                            state_next = ST_FETCH;
                        end
                        default: ;
                    endcase
                end
            end

            ST_FETCH: begin
                step_next = step_reg + 1'b1;
                if (is_read_reg) begin
                    if (step_reg == '0) begin
                        sum_re = 1'b1;
                    end else begin
                        for (int j = 0; j < 3; j++) begin
                            c_next[j] = ok_reg[0] ? CW'($signed(sum_rdata[j*SMW +: SMW]))
                                                  : CW'(0);
                        end
                        s_next     = '0;
                        step_next  = '0;
                        state_next = ST_SQ;
                    end
                end else begin
                    pos_re = (step_reg < STEP_W'(3));
                    case (step_reg[1:0])
                        2'd0:    pos_raddr = AW'(idx_reg[0]);
                        2'd1:    pos_raddr = AW'(idx_reg[1]);
                        default: pos_raddr = AW'(idx_reg[2]);
                    endcase
                    for (int j = 0; j < 3; j++) begin
                        pc = pos_rdata[j*CB +: CB];
                        case (step_reg[1:0])
                            2'd1: p0_next[j] = ok_reg[0] ? pc : CB'(0);
                            2'd2: e1_next[j] = (ok_reg[1] ? EW'(pc) : EW'(0)) - EW'(p0_reg[j]);
                            2'd3: e2_next[j] = (ok_reg[2] ? EW'(pc) : EW'(0)) - EW'(p0_reg[j]);
                            default: ;
                        endcase
                        if (step_reg[1:0] == 2'd3) begin
                            c_next[j] = '0;
                        end
                    end
                    if (step_reg[1:0] == 2'd3) begin
                        step_next  = '0;
                        state_next = ST_CROSS;
                    end
                end
            end

            ST_CROSS: begin
                // products in pairs: c_x = y1*z2 - z1*y2, and so on
                if (step_reg < STEP_W'(mfvn_pkg::CROSS_PRODUCTS)) begin
                    mul_en    = 1'b1;
                    pv_next   = 1'b1;
                    tag_next  = step_reg[3:0];
                    step_next = step_reg + 1'b1;
                    case (step_reg[2:0])
                        3'd0:    begin mul_a = MUL_W'(e1_reg[1]); mul_b = MUL_W'(e2_reg[2]); end
                        3'd1:    begin mul_a = MUL_W'(e1_reg[2]); mul_b = MUL_W'(e2_reg[1]); end
                        3'd2:    begin mul_a = MUL_W'(e1_reg[2]); mul_b = MUL_W'(e2_reg[0]); end
                        3'd3:    begin mul_a = MUL_W'(e1_reg[0]); mul_b = MUL_W'(e2_reg[2]); end
                        3'd4:    begin mul_a = MUL_W'(e1_reg[0]); mul_b = MUL_W'(e2_reg[1]); end
                        default: begin mul_a = MUL_W'(e1_reg[1]); mul_b = MUL_W'(e2_reg[0]); end
                    endcase
                end
                if (pv_reg) begin
                    if (tag_reg[0]) begin
                        c_next[tag_reg[2:1]] = c_reg[tag_reg[2:1]] - CW'(prod);
                    end else begin
                        c_next[tag_reg[2:1]] = c_reg[tag_reg[2:1]] + CW'(prod);
                    end
                    if (step_reg == STEP_W'(mfvn_pkg::CROSS_PRODUCTS)) begin
                        s_next     = '0;
                        step_next  = '0;
                        state_next = ST_SQ;
                    end
                end
            end

            ST_SQ: begin
                // |c|^2 = hi^2 << 2HB + 2*hi*lo << HB + lo^2
                if (step_reg < STEP_W'(mfvn_pkg::SQ_PRODUCTS)) begin
                    sel       = mfvn_pkg::sq_sel(step_reg[3:0]);
                    mv        = mag_of(c_reg[sel.comp]);
                    hi        = mv[MW-1:HB];
                    lo        = mv[HB-1:0];
                    mul_en    = 1'b1;
                    pv_next   = 1'b1;
                    tag_next  = step_reg[3:0];
                    step_next = step_reg + 1'b1;
                    case (sel.part)
                        mfvn_pkg::PART_HH: begin
                            mul_a = $signed(MUL_W'(hi)); mul_b = $signed(MUL_W'(hi));
                        end
                        mfvn_pkg::PART_HL: begin
                            mul_a = $signed(MUL_W'(hi)); mul_b = $signed(MUL_W'(lo));
                        end
                        default: begin
                            mul_a = $signed(MUL_W'(lo)); mul_b = $signed(MUL_W'(lo));
                        end
                    endcase
                end
                if (pv_reg) begin
                    sel = mfvn_pkg::sq_sel(tag_reg);
                    case (sel.part)
                        mfvn_pkg::PART_HH: addend = SW'(prod[2*HB-1:0]) << (2 * HB);
                        mfvn_pkg::PART_HL: addend = SW'(prod[2*HB-1:0]) << (HB + 1);
                        default:           addend = SW'(prod[2*HB-1:0]);
                    endcase
                    s_next = s_reg + addend;
                    if (step_reg == STEP_W'(mfvn_pkg::SQ_PRODUCTS)) begin
                        rem_next   = '0;
                        root_next  = '0;
                        step_next  = '0;
                        state_next = ST_SQRT;
                    end
                end
            end

            ST_SQRT: begin
                // restoring square root, one result bit per cycle
                sub_a  = {rem_reg[SUB_W-3:0], s_reg[SW-1:SW-2]};
                sub_b  = SUB_W'({root_reg, 2'b01});
                s_next = s_reg << 2;
                if (sub_ge) begin
                    rem_next  = sub_diff;
                    root_next = {root_reg[NSQ-2:0], 1'b1};
                end else begin
                    rem_next  = sub_a;
                    root_next = {root_reg[NSQ-2:0], 1'b0};
                end
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(NSQ - 1)) begin
                    step_next = '0;
                    comp_next = '0;
                    q_next    = '0;
                    if (root_next == '0) begin
                        n_next     = '{default: '0};
                        deg_next   = 1'b1;
                        state_next = ST_EMIT;
                    end else begin
                        deg_next   = 1'b0;
                        rem_next   = SUB_W'(mag_of(c_reg[0]));
                        state_next = ST_DIV;
                    end
                end
            end

            ST_DIV: begin
                // |c| <= len, so the first quotient bit needs no shift
                sub_a     = (step_reg == '0) ? rem_reg : (rem_reg << 1);
                sub_b     = SUB_W'(root_reg);
                qf        = {q_reg[QW-2:0], sub_ge};
                q_next    = qf;
                rem_next  = sub_ge ? sub_diff : sub_a;
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(mfvn_pkg::DIV_STEPS - 1)) begin
                    qs = NW'(qf);
                    n_next[comp_reg] = c_reg[comp_reg][CW-1] ? -qs : qs;
                    step_next = '0;
                    q_next    = '0;
                    if (comp_reg == 2'd2) begin
                        state_next = ST_EMIT;
                    end else begin
                        comp_next = comp_reg + 2'd1;
                        rem_next  = SUB_W'(mag_of(c_reg[comp_reg + 2'd1]));
                    end
                end
            end

            ST_EMIT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = is_read_reg ? mfvn_pkg::KIND_VERTEX : mfvn_pkg::KIND_FACE;
                    m_idx_next   = idx_reg[0];
                    m_n_next     = n_reg;
                    m_deg_next   = deg_reg;
                    comp_next    = '0;
                    wb_ph_next   = 1'b0;
                    state_next   = is_read_reg ? ST_IDLE : ST_WB;
                end
            end

            ST_WB: begin
                // read-modify-write of each in-range corner's sums
                sum_raddr = AW'(idx_reg[comp_reg]);
                sum_waddr = AW'(idx_reg[comp_reg]);
                for (int j = 0; j < 3; j++) begin
                    sum_wdata[j*SMW +: SMW] = sat_add(sum_rdata[j*SMW +: SMW], n_reg[j]);
                end
                if (ok_reg[comp_reg] && !wb_ph_reg) begin
                    sum_re     = 1'b1;
                    wb_ph_next = 1'b1;
                end else begin
                    sum_we     = ok_reg[comp_reg];
                    wb_ph_next = 1'b0;
                    if (comp_reg == 2'd2) begin
                        state_next = ST_IDLE;
                    end else begin
                        comp_next = comp_reg + 2'd1;
                    end
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            step_reg    <= '0;
            comp_reg    <= '0;
            tag_reg     <= '0;
            pv_reg      <= 1'b0;
            wb_ph_reg   <= 1'b0;
            clr_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            comp_reg    <= comp_next;
            tag_reg     <= tag_next;
            pv_reg      <= pv_next;
            wb_ph_reg   <= wb_ph_next;
            clr_cnt_reg <= clr_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        is_read_reg <= is_read_next;
        idx_reg     <= idx_next;
        ok_reg      <= ok_next;
        p0_reg      <= p0_next;
        e1_reg      <= e1_next;
        e2_reg      <= e2_next;
        c_reg       <= c_next;
        s_reg       <= s_next;
        rem_reg     <= rem_next;
        root_reg    <= root_next;
        q_reg       <= q_next;
        n_reg       <= n_next;
        deg_reg     <= deg_next;
        m_kind_reg  <= m_kind_next;
        m_idx_reg   <= m_idx_next;
        m_n_reg     <= m_n_next;
        m_deg_reg   <= m_deg_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, m_n_reg[2], m_n_reg[1], m_n_reg[0], m_idx_reg};
    assign m_tuser  = {m_deg_reg, m_kind_reg};

endmodule

`default_nettype wire

>>> hw/rtl/mfvn_checker.sv
`default_nettype none

`include "mesh_face_vertex_normals_core_assert.svh"

module mfvn_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic [1:0]                    s_tuser,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [mfvn_pkg::M_DATA_W-1:0] m_tdata,
    input wire logic [1:0]                    m_tuser
);

    logic out_stall;
    logic long_cmd;
    logic deg_shown;

    assign out_stall = m_tvalid && !m_tready;
    assign long_cmd  = s_tvalid && s_tready
                       && (s_tuser == mfvn_pkg::CMD_TRI || s_tuser == mfvn_pkg::CMD_READ);
    assign deg_shown = m_tvalid && m_tuser[1];

    `MFVN_ASSERT_NXT(a_out_hold, aclk, aresetn, out_stall, m_tvalid)
    `MFVN_ASSERT_NXT(a_out_stable, aclk, aresetn, out_stall, $stable(m_tdata) && $stable(m_tuser))
    `MFVN_ASSERT_NXT(a_busy_after_cmd, aclk, aresetn, long_cmd, !s_tready)
    `MFVN_ASSERT_IMP(a_degenerate_zero, aclk, aresetn, deg_shown, m_tdata[57:10] == 48'd0)

endmodule

bind mesh_face_vertex_normals_core mfvn_checker u_mfvn_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
